@@ rtl/dqm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_pkg
// shared types and constants of the descriptor queue manager
// ----------------------------------------------------------------------------
package dqm_pkg;
  localparam int NumDescsDef = 1024;
  localparam int NumQueuesDef = 3;
  localparam int WordBitsDef = 64;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE = 3'd1,
    ACT_ENQ = 3'd2,
    ACT_DEQ = 3'd3,
    ACT_SETC = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOT_EMPTY = 2'd2,
    ST_NO_REPLICA = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] queue_sel;
    logic [9:0] desc_index;
    logic [63:0] payload_first;
    logic [63:0] payload_second;
    logic [1:0] new_color;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] result_index;
    logic [63:0] result_first;
    logic [63:0] result_second;
    logic [1:0] result_color;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic rd_a;
    logic rd_b;
    logic exec;
    logic fin;
  } dqm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_done;
  } dqm_stat_t;
endpackage

@@ rtl/dqm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_ctrl
// sequencer: reset sweep, then read, read, execute, respond per request
// ----------------------------------------------------------------------------
module dqm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  dqm_pkg::dqm_stat_t stat,
  output dqm_pkg::dqm_cmd_t cmd,
  output logic busy
);
  import dqm_pkg::*;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_RDA = 6'b000100,
    S_RDB = 6'b001000,
    S_EXEC = 6'b010000,
    S_FIN = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (stat.init_done) state_next = S_IDLE;
      S_IDLE: if (start) state_next = S_RDA;
      S_RDA: state_next = S_RDB;
      S_RDB: state_next = S_EXEC;
      S_EXEC: state_next = S_FIN;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign cmd.init = (state == S_INIT);
  assign cmd.rd_a = (state == S_RDA);
  assign cmd.rd_b = (state == S_RDB);
  assign cmd.exec = (state == S_EXEC);
  assign cmd.fin = (state == S_FIN);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_seq: assert property (@(posedge clk) disable iff (rst) cmd.rd_a |=> cmd.rd_b)
    else $error("read sequence broken");
  a_fin: assert property (@(posedge clk) disable iff (rst) cmd.exec |=> cmd.fin)
    else $error("exec not followed by fin");
endmodule

@@ rtl/dqm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_datapath
// link memory (valid, next, color), word memories, queue registers and free list top
// ----------------------------------------------------------------------------
module dqm_datapath #(
  parameter int NUM_DESCS = dqm_pkg::NumDescsDef,
  parameter int NUM_QUEUES = dqm_pkg::NumQueuesDef,
  parameter int WORD_BITS = dqm_pkg::WordBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic start_acc,
  input  dqm_pkg::req_t req,
  input  dqm_pkg::dqm_cmd_t cmd,
  output dqm_pkg::dqm_stat_t stat,
  output dqm_pkg::rsp_t rsp,
  output logic done
);
  import dqm_pkg::*;

  localparam int IW = (NUM_DESCS > 1) ? $clog2(NUM_DESCS) : 1;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LW = IW + 1;

  // link entry: valid, next, color
  logic [LW+1:0] link_mem [NUM_DESCS];
  logic [WORD_BITS-1:0] wf_mem [NUM_DESCS];
  logic [WORD_BITS-1:0] ws_mem [NUM_DESCS];

  logic [IW-1:0] queue_head [NUM_QUEUES];
  logic [IW-1:0] queue_tail [NUM_QUEUES];
  logic [IW-1:0] free_top;
  logic free_valid;

  req_t r;
  logic [IW:0] init_cnt;
  logic init_done_q;

  // read ports
  logic [IW-1:0] la_addr, lb_addr;
  logic [LW+1:0] la_q, lb_q, lc_q;
  logic [WORD_BITS-1:0] wf_q, ws_q;

  logic qok, iok;
  logic [QW-1:0] qi;
  logic [IW-1:0] di, h, t, fidx;
  logic [WORD_BITS-1:0] mask_w;

  assign qok = ({30'd0, r.queue_sel} < 32'(NUM_QUEUES));
  assign iok = ({22'd0, r.desc_index} < 32'(NUM_DESCS));
  assign qi = QW'(r.queue_sel);
  assign di = IW'(r.desc_index);
  assign h = queue_head[qok ? qi : '0];
  assign t = queue_tail[qok ? qi : '0];
  assign fidx = free_top;
  assign mask_w = '1;

  // first read: link of head (dequeue, set) or tail (enqueue), free top for pop
  // second read: link and words of head's next node
  logic [IW-1:0] n;
  assign n = la_q[IW+1:2];

  always_comb begin
    la_addr = h;
    case (action_t'(r.action))
      ACT_ENQ: la_addr = t;
      ACT_ALLOC: la_addr = fidx;
      default: la_addr = h;
    endcase
  end
  assign lb_addr = cmd.rd_b ? n : fidx;

  // reset sweep value
  logic [IW:0] iv;
  logic [LW+1:0] init_word;
  always_comb begin
    iv = init_cnt;
    init_word = '0;
    if (iv < (IW+1)'(NUM_DESCS - NUM_QUEUES) && iv != '0) begin
      init_word = {1'b1, IW'(iv - 1'b1), 2'd0};
    end else if (iv == (IW+1)'(NUM_DESCS - 1)) begin
      init_word = {1'b0, {IW{1'b0}}, 2'd1};
    end
  end

  logic wa_en, wb_en, ww_en;
  logic [IW-1:0] wa_addr, wb_addr, ww_addr;
  logic [LW+1:0] wa_data, wb_data;
  logic [WORD_BITS-1:0] ww_f, ww_s;

  always_ff @(posedge clk) begin
    if (cmd.rd_a) la_q <= link_mem[la_addr];
    if (cmd.rd_a) lc_q <= link_mem[fidx];
    if (cmd.rd_b) begin
      lb_q <= link_mem[lb_addr];
      wf_q <= wf_mem[lb_addr];
      ws_q <= ws_mem[lb_addr];
    end
    if (wa_en) link_mem[wa_addr] <= wa_data;
    if (wb_en) link_mem[wb_addr] <= wb_data;
    if (ww_en) begin
      wf_mem[ww_addr] <= ww_f;
      ws_mem[ww_addr] <= ww_s;
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) r <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
      init_done_q <= 1'b0;
    end else if (cmd.init && !init_done_q) begin
      if (init_cnt == (IW+1)'(NUM_DESCS - 1)) init_done_q <= 1'b1;
      else init_cnt <= init_cnt + 1'b1;
    end
  end
  assign stat.init_done = init_done_q;

  // execute step
  rsp_t rsp_next;
  logic [IW-1:0] nn;
  logic [IW-1:0] head_n, tail_n, ftop_n;
  logic fvalid_n, hq_we, tq_we;

  assign nn = la_q[IW+1:2];

  always_comb begin
    rsp_next = '0;
    wa_en = 1'b0; wb_en = 1'b0; ww_en = 1'b0;
    wa_addr = '0; wb_addr = '0; ww_addr = '0;
    wa_data = '0; wb_data = '0; ww_f = '0; ww_s = '0;
    head_n = h; tail_n = t; hq_we = 1'b0; tq_we = 1'b0;
    ftop_n = free_top; fvalid_n = free_valid;
    if (cmd.init && !init_done_q) begin
      wa_en = 1'b1;
      wa_addr = IW'(init_cnt);
      wa_data = init_word;
    end else if (cmd.exec) begin
      case (action_t'(r.action))
        ACT_ALLOC: begin
          if (free_valid) begin
            rsp_next.result_index = 10'(free_top);
            fvalid_n = la_q[LW+1];
            ftop_n = la_q[IW+1:2];
          end else begin
            rsp_next.status = ST_EMPTY;
          end
        end
        ACT_FREE: begin
          if (iok) begin
            wa_en = 1'b1; wa_addr = di;
            wa_data = {free_valid, free_top, 2'd0};
            ftop_n = di; fvalid_n = 1'b1;
          end
        end
        ACT_ENQ: begin
          if (!qok) rsp_next.status = ST_EMPTY;
          else if (iok) begin
            ww_en = 1'b1; ww_addr = di;
            ww_f = r.payload_first[WORD_BITS-1:0] & mask_w;
            ww_s = r.payload_second[WORD_BITS-1:0] & mask_w;
            wa_en = 1'b1; wa_addr = t;
            wa_data = {1'b1, di, la_q[1:0]};
            wb_en = (di != t); wb_addr = di;
            wb_data = {1'b0, {IW{1'b0}}, la_q[1:0]};
            if (di == t) wa_data = {1'b1, di, la_q[1:0]};
            tail_n = di; tq_we = 1'b1;
            rsp_next.result_color = la_q[1:0];
          end
        end
        ACT_DEQ: begin
          if (!qok) rsp_next.status = ST_EMPTY;
          else if (!la_q[LW+1]) rsp_next.status = ST_EMPTY;
          else begin
            if (t == h) begin
              tail_n = nn; tq_we = 1'b1;
            end
            if (!free_valid) rsp_next.status = ST_NO_REPLICA;
            else begin
              // replica r = free_top; then old head pushed on top of r's successor
              ww_en = 1'b1; ww_addr = free_top;
              ww_f = wf_q; ww_s = ws_q;
              wa_en = 1'b1; wa_addr = free_top;
              wa_data = {lc_q[LW+1:2], lb_q[1:0]};
              wb_en = 1'b1; wb_addr = h;
              wb_data = {lc_q[LW+1:2], 2'd0};
              ftop_n = h; fvalid_n = 1'b1;
              head_n = nn; hq_we = 1'b1;
              rsp_next.result_index = 10'(free_top);
              rsp_next.result_first = 64'(wf_q);
              rsp_next.result_second = 64'(ws_q);
              rsp_next.result_color = lb_q[1:0];
            end
          end
        end
        ACT_SETC: begin
          if (!qok) rsp_next.status = ST_EMPTY;
          else if (t != h || la_q[LW+1]) rsp_next.status = ST_NOT_EMPTY;
          else begin
            rsp_next.result_color = la_q[1:0];
            wa_en = 1'b1; wa_addr = h;
            wa_data = {la_q[LW+1:2], r.new_color};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        queue_head[q] <= (NUM_DESCS - 1 - q >= 0) ? IW'(NUM_DESCS - 1 - q) : '0;
        queue_tail[q] <= (NUM_DESCS - 1 - q >= 0) ? IW'(NUM_DESCS - 1 - q) : '0;
      end
      free_top <= IW'(NUM_DESCS - 1 - NUM_QUEUES);
      free_valid <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        if (hq_we) queue_head[qi] <= head_n;
        if (tq_we) queue_tail[qi] <= tail_n;
        free_top <= ftop_n;
        free_valid <= fvalid_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) rsp <= rsp_next;
  end

  a_done: assert property (@(posedge clk) disable iff (rst) done |-> cmd.fin)
    else $error("result outside fin step");
  a_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && action_t'(r.action) == ACT_FREE && iok |=> free_valid)
    else $error("free list empty after free");
  a_init: assert property (@(posedge clk) disable iff (rst)
    init_done_q |=> init_done_q)
    else $error("init done dropped");
endmodule

@@ rtl/descriptor_queue_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_queue_manager
// linked descriptor pool with a free list and fifo queues
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low. each request
// produces one result, shown for one cycle with done high.
// a request runs through two dependent reads of the single link memory,
// one execute step that writes it and one result step; busy stays high
// until the result has been shown, so a new request is taken only after
// the previous one is done.
// after reset the link memory is swept once, one entry per cycle, over all
// NUM_DESCS entries, building the free chain and queue heads; busy is high
// throughout. descriptor words are not cleared and read as anything until
// written. results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module descriptor_queue_manager #(
  parameter int NUM_DESCS = dqm_pkg::NumDescsDef,
  parameter int NUM_QUEUES = dqm_pkg::NumQueuesDef,
  parameter int WORD_BITS = dqm_pkg::WordBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  dqm_pkg::req_t req,
  output logic done,
  output dqm_pkg::rsp_t rsp
);
  import dqm_pkg::*;

  dqm_cmd_t cmd;
  dqm_stat_t stat;

  dqm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  dqm_datapath #(
    .NUM_DESCS(NUM_DESCS), .NUM_QUEUES(NUM_QUEUES), .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .start_acc(start && !busy), .req(req), .cmd(cmd),
    .stat(stat), .rsp(rsp), .done(done)
  );
endmodule
